// ===== design/crcpc_pkg.sv =====
// ----------------------------------------------------------------------------
// crcpc_pkg
// shared types, constants and the crc-16/arc word update for the packet checker
// ----------------------------------------------------------------------------
package crcpc_pkg;

  localparam int unsigned WORD_W         = 16;
  localparam int unsigned POS_W          = 3;
  localparam int unsigned PACKET_WORDS_D = 6;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned ADDR_W         = 3;
  localparam int unsigned DATA_W         = 32;

  localparam logic [WORD_W-1:0] CRC_POLY     = 16'hA001;
  localparam logic [WORD_W-1:0] EXP_LEN_RST  = 16'd6;
  localparam logic [ADDR_W-1:0] ADDR_EXP_LEN = 3'd0;

  // role of a word inside the packet, set by the front end
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_LENGTH,
    KIND_BODY,
    KIND_CRC
  } word_kind_t;

  // one classified word as it sits in the queue
  typedef struct packed {
    logic [WORD_W-1:0] word;
    word_kind_t        kind;
  } q_entry_t;

  // crc-16/arc over one word, high byte first; reflected, so lsb-first per
  // bit, which unrolls to a fixed xor matrix
  function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] c,
                                                 input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] acc;
    acc = c ^ {8'h00, w[15:8]};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    acc = acc ^ {8'h00, w[7:0]};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction

endpackage

// ===== design/crcpc_front.sv =====
// ----------------------------------------------------------------------------
// crcpc_front
// tracks word position and tags each accepted beat with its role in the packet
// ----------------------------------------------------------------------------
module crcpc_front #(
  parameter int unsigned PACKET_WORDS = crcpc_pkg::PACKET_WORDS_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [crcpc_pkg::WORD_W-1:0] in_data_word,
  input  logic                         in_first_word,
  input  logic                         q_full,
  output logic                         push,
  output crcpc_pkg::q_entry_t          push_entry
);

  localparam logic [crcpc_pkg::POS_W-1:0] LAST_POS =
    crcpc_pkg::POS_W'(PACKET_WORDS - 1);

  logic [crcpc_pkg::POS_W-1:0] pos_r;
  logic [crcpc_pkg::POS_W-1:0] pos_nxt;
  logic [crcpc_pkg::POS_W-1:0] pos_cur;
  crcpc_pkg::word_kind_t       kind;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // first-word flag forces a new header
  assign pos_cur = in_first_word ? '0 : pos_r;

  // classify the beat
  always_comb begin
    priority if (pos_cur == '0) begin
      kind = crcpc_pkg::KIND_HEADER;
    end else if (pos_cur >= LAST_POS) begin
      kind = crcpc_pkg::KIND_CRC;
    end else if (pos_cur == crcpc_pkg::POS_W'(1)) begin
      kind = crcpc_pkg::KIND_LENGTH;
    end else begin
      kind = crcpc_pkg::KIND_BODY;
    end
  end

  assign push_entry.word = in_data_word;
  assign push_entry.kind = kind;

  // next position, back to zero after the crc word
  always_comb begin
    pos_nxt = pos_r;
    if (push) begin
      pos_nxt = (kind == crcpc_pkg::KIND_CRC) ? '0 : pos_cur + crcpc_pkg::POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

endmodule

// ===== design/crcpc_queue.sv =====
// ----------------------------------------------------------------------------
// crcpc_queue
// short fifo of classified words between the front and back ends
// ----------------------------------------------------------------------------
module crcpc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  crcpc_pkg::q_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                head_valid,
  output crcpc_pkg::q_entry_t head_entry
);

  localparam int unsigned DEPTH = crcpc_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  crcpc_pkg::q_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_pop;

  assign full       = (count_r == FULL_CNT);
  assign head_valid = (count_r != '0);
  assign head_entry = entries_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== design/crcpc_back.sv =====
// ----------------------------------------------------------------------------
// crcpc_back
// runs the crc, holds header and length check, and registers the verdict beat
// ----------------------------------------------------------------------------
module crcpc_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  crcpc_pkg::q_entry_t          head_entry,
  output logic                         pop,
  input  logic [crcpc_pkg::WORD_W-1:0] exp_len,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [crcpc_pkg::WORD_W-1:0] out_header_out,
  output logic                         out_accepted
);

  logic [crcpc_pkg::WORD_W-1:0] crc_r, crc_nxt;
  logic [crcpc_pkg::WORD_W-1:0] hdr_r, hdr_nxt;
  logic                         len_ok_r, len_ok_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [crcpc_pkg::WORD_W-1:0] out_hdr_r;
  logic                         out_acc_r;
  logic [crcpc_pkg::WORD_W-1:0] crc_upd;
  logic                         is_crc;
  logic                         load;
  logic                         ok;

  assign is_crc  = (head_entry.kind == crcpc_pkg::KIND_CRC);
  // a crc word waits only while the output register is held
  assign pop     = head_valid && (!is_crc || !out_valid_r || !out_stall);
  assign load    = pop && is_crc;
  assign crc_upd = crcpc_pkg::crc_word(crc_r, head_entry.word);
  assign ok      = len_ok_r && (crc_r == head_entry.word);

  // packet state update
  always_comb begin
    crc_nxt    = crc_r;
    hdr_nxt    = hdr_r;
    len_ok_nxt = len_ok_r;
    if (pop) begin
      unique case (head_entry.kind)
        crcpc_pkg::KIND_HEADER: begin
          hdr_nxt    = head_entry.word;
          len_ok_nxt = 1'b0;
          crc_nxt    = crcpc_pkg::crc_word('0, head_entry.word);
        end
        crcpc_pkg::KIND_LENGTH: begin
          len_ok_nxt = (head_entry.word == exp_len);
          crc_nxt    = crc_upd;
        end
        crcpc_pkg::KIND_BODY: begin
          crc_nxt = crc_upd;
        end
        crcpc_pkg::KIND_CRC: begin
          crc_nxt = '0;
        end
        default: begin
          crc_nxt = crc_r;
        end
      endcase
    end
  end

  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= '0;
      hdr_r       <= '0;
      len_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      hdr_r       <= hdr_nxt;
      len_ok_r    <= len_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // verdict payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_hdr_r <= ok ? hdr_r : '0;
      out_acc_r <= ok;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_header_out = out_hdr_r;
  assign out_accepted   = out_acc_r;

endmodule

// ===== design/crc16_arc_word_packet_checker.sv =====
// ----------------------------------------------------------------------------
// crc16_arc_word_packet_checker
// fixed-length word packet checker with crc-16/arc and length match
// ----------------------------------------------------------------------------
// the crc word passes through the queue and, once the output register is free,
// loads it; the verdict beat is shown from that register
// throughput: one word per cycle, set by the combinational two-byte crc update
// in the back end; stalls only once the two-entry queue is full
// reset: synchronous active-low rst_n clears position, queue, crc state and
// output valid; expected_length returns to 6
module crc16_arc_word_packet_checker #(
  parameter int unsigned PACKET_WORDS = crcpc_pkg::PACKET_WORDS_D
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [crcpc_pkg::WORD_W-1:0] in_data_word,
  input  logic                         in_first_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [crcpc_pkg::WORD_W-1:0] out_header_out,
  output logic                         out_accepted,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [crcpc_pkg::ADDR_W-1:0] paddr,
  input  logic [crcpc_pkg::DATA_W-1:0] pwdata,
  output logic [crcpc_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);

  logic [crcpc_pkg::WORD_W-1:0] exp_len_r, exp_len_nxt;
  logic                         q_full;
  logic                         push;
  crcpc_pkg::q_entry_t          push_entry;
  logic                         pop;
  logic                         head_valid;
  crcpc_pkg::q_entry_t          head_entry;
  logic                         wr_en;

  // register port
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr == crcpc_pkg::ADDR_EXP_LEN);
  assign exp_len_nxt = wr_en ? pwdata[crcpc_pkg::WORD_W-1:0] : exp_len_r;
  assign prdata = (paddr == crcpc_pkg::ADDR_EXP_LEN) ?
                  {{(crcpc_pkg::DATA_W - crcpc_pkg::WORD_W){1'b0}}, exp_len_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= crcpc_pkg::EXP_LEN_RST;
    end else begin
      exp_len_r <= exp_len_nxt;
    end
  end

  crcpc_front #(
    .PACKET_WORDS(PACKET_WORDS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_word (in_data_word),
    .in_first_word(in_first_word),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  crcpc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head_entry(head_entry)
  );

  crcpc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .exp_len       (exp_len_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_header_out(out_header_out),
    .out_accepted  (out_accepted)
  );

endmodule

// ===== design/crcpc_checker.sv =====
// ----------------------------------------------------------------------------
// crcpc_checker
// port-level checks on the packet checker, bound to the top level
// ----------------------------------------------------------------------------
module crcpc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [crcpc_pkg::WORD_W-1:0] out_header_out,
  input logic                         out_accepted
);

  // a held verdict beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_header_out) &&
                               $stable(out_accepted))
    else $error("verdict beat changed while stalled");

  // a rejected packet reports a zero header
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_accepted |-> out_header_out == '0)
    else $error("rejected packet with non-zero header");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("verdict beat pending after reset");

  // reset empties the queue so input is taken at once
  a_rst_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind crc16_arc_word_packet_checker crcpc_checker u_crcpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_header_out(out_header_out),
  .out_accepted  (out_accepted)
);
